// ----- rtl/lcdr_pkg.sv -----
// Shared constants, types and codes of the LCD register file with timing status.
package lcdr_pkg;

  // Video timing
  localparam int unsigned DotsPerLine   = 456;
  localparam int unsigned LinesPerFrame = 154;
  localparam int unsigned DotsPerFrame  = DotsPerLine * LinesPerFrame;
  localparam int unsigned VisibleLines  = 144;
  localparam int unsigned OamScanEnd    = 80;
  localparam int unsigned TransferEnd   = 280;

  // Field widths
  localparam int unsigned TsW     = 64;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OffsetW = 4;
  localparam int unsigned FrameW  = $clog2(DotsPerFrame);
  localparam int unsigned LineW   = $clog2(LinesPerFrame);
  localparam int unsigned DotW    = $clog2(DotsPerLine);

  // Timestamp folding: four 16-bit chunks times 2^(16*i) mod frame length
  localparam int unsigned ChunkW  = 16;
  localparam int unsigned NumChunks = TsW / ChunkW;
  localparam int unsigned ProdW   = ChunkW + FrameW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned HiW     = SumW - ChunkW;
  localparam logic [FrameW-1:0] Res0  = FrameW'(1);
  localparam logic [FrameW-1:0] Res16 = FrameW'((64'd1 << 16) % DotsPerFrame);
  localparam logic [FrameW-1:0] Res32 = FrameW'((64'd1 << 32) % DotsPerFrame);
  localparam logic [FrameW-1:0] Res48 = FrameW'((64'd1 << 48) % DotsPerFrame);

  // Reciprocal quotient estimate of the folded sum; it falls short by at most two
  localparam int unsigned     RecipK = HiW + 2;
  localparam longint unsigned Recip  = (64'd1 << (ChunkW + RecipK)) / DotsPerFrame;
  localparam int unsigned     RecipW = $clog2(Recip + 1);
  localparam int unsigned     QMulW  = HiW + RecipW;
  localparam int unsigned     QuotW  = QMulW - RecipK;
  localparam int unsigned     ResW   = FrameW + 2;

  // Exact line number from the dot within the frame
  localparam int unsigned     LineK      = FrameW + $clog2(DotsPerLine);
  localparam longint unsigned LineRecip  = ((64'd1 << LineK) + DotsPerLine - 1) / DotsPerLine;
  localparam int unsigned     LineRecipW = $clog2(LineRecip + 1);
  localparam int unsigned     LMulW      = FrameW + LineRecipW;

  // Compare-line target within a frame, plus one frame when already passed
  localparam int unsigned TgtW = DataW + $clog2(DotsPerLine);
  localparam int unsigned AdjW = $clog2(255 * DotsPerLine + DotsPerFrame + 1);

  // Pipeline depth: the input register, seven datapath stages, the result register
  localparam int unsigned NumStages = 9;

  typedef enum logic {
    AccRead  = 1'b0,
    AccWrite = 1'b1
  } access_e;

  typedef enum logic [OffsetW-1:0] {
    OffLcdc = 4'd0,
    OffStat = 4'd1,
    OffScy  = 4'd2,
    OffScx  = 4'd3,
    OffLy   = 4'd4,
    OffLyc  = 4'd5,
    OffDma  = 4'd6,
    OffBgp  = 4'd7,
    OffObp0 = 4'd8,
    OffObp1 = 4'd9,
    OffWy   = 4'd10,
    OffWx   = 4'd11
  } reg_offset_e;

  typedef enum logic [1:0] {
    ModeHblank   = 2'd0,
    ModeVblank   = 2'd1,
    ModeOamScan  = 2'd2,
    ModeTransfer = 2'd3
  } stat_mode_e;

  // Command part of a request, carried down the pipeline
  typedef struct packed {
    logic               is_write;
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   wdata;
  } acc_t;

  // Timing of a request as seen by the register stage
  typedef struct packed {
    acc_t             acc;
    logic [LineW-1:0] line;
    logic [DotW-1:0]  dot;
    logic [TsW-1:0]   start;
    logic [AdjW-1:0]  tgt;
  } pos_t;

  // Stage load strobes from the pipeline control
  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctl_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             unimplemented;
    logic             log_valid;
    logic [7:0]       log_scanline;
    logic             compare_event_valid;
    logic [TsW-1:0]   compare_event_time;
  } rsp_t;

endpackage

// ----- rtl/lcdr_req_if.sv -----
// Request channel: one bus access with its dot timestamp.
interface lcdr_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [lcdr_pkg::OffsetW-1:0] reg_offset;
  logic [lcdr_pkg::DataW-1:0]   write_data;
  logic [lcdr_pkg::TsW-1:0]     timestamp;

  modport source (output valid, req_type, reg_offset, write_data, timestamp, input ready);
  modport sink   (input valid, req_type, reg_offset, write_data, timestamp, output ready);
endinterface

// ----- rtl/lcdr_rsp_if.sv -----
// Result channel: read data, log and compare-event report of one access.
interface lcdr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lcdr_pkg::DataW-1:0] read_data;
  logic                       unimplemented;
  logic                       log_valid;
  logic [7:0]                 log_scanline;
  logic                       compare_event_valid;
  logic [lcdr_pkg::TsW-1:0]   compare_event_time;

  modport source (output valid, read_data, unimplemented, log_valid, log_scanline,
                  compare_event_valid, compare_event_time, input ready);
  modport sink   (input valid, read_data, unimplemented, log_valid, log_scanline,
                  compare_event_valid, compare_event_time, output ready);
endinterface

// ----- rtl/lcdr_pipe_ctrl.sv -----
// Valid chain and load strobes of the request pipeline, with bubble collapsing.
module lcdr_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lcdr_pkg::pipe_ctl_t ctl_o
);

  logic [lcdr_pkg::NumStages-1:0] valid_q, valid_d;
  logic [lcdr_pkg::NumStages:0]   free;
  logic [lcdr_pkg::NumStages-1:0] load;

  // A stage can take a request when empty or when its request moves on
  always_comb begin
    free[lcdr_pkg::NumStages] = out_ready_i;
    for (int k = lcdr_pkg::NumStages - 1; k >= 0; k--) begin
      free[k] = !valid_q[k] || free[k+1];
    end
  end

  always_comb begin
    load[0]    = in_valid_i && free[0];
    valid_d[0] = load[0] || (valid_q[0] && !free[1]);
    for (int k = 1; k < lcdr_pkg::NumStages; k++) begin
      load[k]    = valid_q[k-1] && free[k];
      valid_d[k] = load[k] || (valid_q[k] && !free[k+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = valid_q[lcdr_pkg::NumStages-1];
  assign ctl_o.load  = load;

endmodule

// ----- rtl/lcdr_frame_pos.sv -----
// Timestamp to frame position: dot within frame, line, dot within line, event target.
module lcdr_frame_pos (
  input  logic                        clk_i,
  input  lcdr_pkg::pipe_ctl_t         ctl_i,
  input  lcdr_pkg::acc_t              acc_i,
  input  logic [lcdr_pkg::TsW-1:0]    ts_i,
  output lcdr_pkg::pos_t              pos_o
);

  localparam logic [lcdr_pkg::NumChunks-1:0][lcdr_pkg::FrameW-1:0] ResTab =
    {lcdr_pkg::Res48, lcdr_pkg::Res32, lcdr_pkg::Res16, lcdr_pkg::Res0};

  lcdr_pkg::acc_t acc0_q, acc1_q, acc2_q, acc3_q, acc4_q, acc5_q, acc6_q;
  logic [lcdr_pkg::TsW-1:0] ts0_q, ts1_q, ts2_q, ts3_q, ts4_q, ts5_q;

  logic [lcdr_pkg::NumChunks-1:0][lcdr_pkg::ProdW-1:0] prod_d, prod_q;
  logic [lcdr_pkg::SumW-1:0]   sum_d, sum2_q, sum3_q;
  logic [lcdr_pkg::QMulW-1:0]  qmul;
  logic [lcdr_pkg::QuotW-1:0]  quot_d, quot_q;
  logic [lcdr_pkg::SumW-1:0]   qback, rdiff;
  logic [lcdr_pkg::ResW-1:0]   res_d, res_q, res_c1, res_c2;
  logic [lcdr_pkg::FrameW-1:0] frame_d, frame5_q, frame6_q;
  logic [lcdr_pkg::LMulW-1:0]  lmul;
  logic [lcdr_pkg::LineW-1:0]  line_d, line6_q;
  logic [lcdr_pkg::TsW-1:0]    start_d, start6_q;
  logic [lcdr_pkg::TgtW-1:0]   tgt_d, tgt6_q;
  logic [lcdr_pkg::FrameW-1:0] lback, ddiff;
  lcdr_pkg::pos_t              pos_d, pos_q;

  // Stage 0: input register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      acc0_q <= acc_i;
      ts0_q  <= ts_i;
    end
  end

  // Stage 1: each 16-bit chunk times its weight modulo the frame length
  always_comb begin
    for (int i = 0; i < lcdr_pkg::NumChunks; i++) begin
      prod_d[i] = lcdr_pkg::ProdW'(ts0_q[i*lcdr_pkg::ChunkW +: lcdr_pkg::ChunkW])
                * lcdr_pkg::ProdW'(ResTab[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      acc1_q <= acc0_q;
      ts1_q  <= ts0_q;
      prod_q <= prod_d;
    end
  end

  // Stage 2: folded sum, congruent to the timestamp
  assign sum_d = lcdr_pkg::SumW'(prod_q[0]) + lcdr_pkg::SumW'(prod_q[1])
               + lcdr_pkg::SumW'(prod_q[2]) + lcdr_pkg::SumW'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      acc2_q <= acc1_q;
      ts2_q  <= ts1_q;
      sum2_q <= sum_d;
    end
  end

  // Stage 3: quotient estimate from the upper bits of the sum
  assign qmul   = lcdr_pkg::QMulW'(sum2_q[lcdr_pkg::SumW-1:lcdr_pkg::ChunkW])
                * lcdr_pkg::QMulW'(lcdr_pkg::Recip);
  assign quot_d = qmul[lcdr_pkg::QMulW-1:lcdr_pkg::RecipK];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      acc3_q <= acc2_q;
      ts3_q  <= ts2_q;
      sum3_q <= sum2_q;
      quot_q <= quot_d;
    end
  end

  // Stage 4: partial remainder, below three frames
  assign qback = lcdr_pkg::SumW'(quot_q) * lcdr_pkg::SumW'(lcdr_pkg::DotsPerFrame);
  assign rdiff = sum3_q - qback;
  assign res_d = rdiff[lcdr_pkg::ResW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      acc4_q <= acc3_q;
      ts4_q  <= ts3_q;
      res_q  <= res_d;
    end
  end

  // Stage 5: two correction steps give the dot within the frame
  always_comb begin
    res_c1 = res_q;
    if (res_c1 >= lcdr_pkg::ResW'(lcdr_pkg::DotsPerFrame)) begin
      res_c1 = res_c1 - lcdr_pkg::ResW'(lcdr_pkg::DotsPerFrame);
    end
    res_c2 = res_c1;
    if (res_c2 >= lcdr_pkg::ResW'(lcdr_pkg::DotsPerFrame)) begin
      res_c2 = res_c2 - lcdr_pkg::ResW'(lcdr_pkg::DotsPerFrame);
    end
    frame_d = res_c2[lcdr_pkg::FrameW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[5]) begin
      acc5_q   <= acc4_q;
      ts5_q    <= ts4_q;
      frame5_q <= frame_d;
    end
  end

  // Stage 6: line number, frame start and raw compare target
  assign lmul    = lcdr_pkg::LMulW'(frame5_q) * lcdr_pkg::LMulW'(lcdr_pkg::LineRecip);
  assign line_d  = lmul[lcdr_pkg::LineK +: lcdr_pkg::LineW];
  assign start_d = ts5_q - lcdr_pkg::TsW'(frame5_q);
  assign tgt_d   = lcdr_pkg::TgtW'(acc5_q.wdata) * lcdr_pkg::TgtW'(lcdr_pkg::DotsPerLine);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[6]) begin
      acc6_q   <= acc5_q;
      frame6_q <= frame5_q;
      line6_q  <= line_d;
      start6_q <= start_d;
      tgt6_q   <= tgt_d;
    end
  end

  // Stage 7: dot within the line and target moved to the next frame if passed
  assign lback = lcdr_pkg::FrameW'(line6_q) * lcdr_pkg::FrameW'(lcdr_pkg::DotsPerLine);
  assign ddiff = frame6_q - lback;

  always_comb begin
    pos_d.acc   = acc6_q;
    pos_d.line  = line6_q;
    pos_d.dot   = ddiff[lcdr_pkg::DotW-1:0];
    pos_d.start = start6_q;
    if (lcdr_pkg::AdjW'(frame6_q) > lcdr_pkg::AdjW'(tgt6_q)) begin
      pos_d.tgt = lcdr_pkg::AdjW'(tgt6_q) + lcdr_pkg::AdjW'(lcdr_pkg::DotsPerFrame);
    end else begin
      pos_d.tgt = lcdr_pkg::AdjW'(tgt6_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[7]) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ----- rtl/lcdr_regfile.sv -----
// LCD registers, read mux with LY/STAT, write decode and the result register.
module lcdr_regfile (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  lcdr_pkg::pos_t  pos_i,
  output lcdr_pkg::rsp_t  rsp_o
);

  logic [7:0]      lcdc_q, lcdc_d;
  logic [3:0]      stat_hi_q, stat_hi_d;
  logic [7:0]      scy_q, scy_d;
  logic [7:0]      scx_q, scx_d;
  logic [7:0]      lyc_q, lyc_d;
  logic [7:0]      bgp_q, bgp_d;
  logic [1:0][7:0] obp_q, obp_d;
  logic [1:0][7:0] wpos_q, wpos_d;

  lcdr_pkg::rsp_t     rsp_d, rsp_q;
  lcdr_pkg::stat_mode_e mode;
  logic               coinc;
  logic [7:0]         stat_val;
  logic [7:0]         ly_val;
  logic               logged;

  // STAT: mode from line and dot thresholds, coincidence with the compare line
  assign ly_val = 8'(pos_i.line);
  assign coinc  = (ly_val == lyc_q);

  always_comb begin
    if (pos_i.line >= lcdr_pkg::LineW'(lcdr_pkg::VisibleLines)) begin
      mode = lcdr_pkg::ModeVblank;
    end else if (pos_i.dot <= lcdr_pkg::DotW'(lcdr_pkg::OamScanEnd)) begin
      mode = lcdr_pkg::ModeOamScan;
    end else if (pos_i.dot <= lcdr_pkg::DotW'(lcdr_pkg::TransferEnd)) begin
      mode = lcdr_pkg::ModeTransfer;
    end else begin
      mode = lcdr_pkg::ModeHblank;
    end
  end

  assign stat_val = {stat_hi_q, 1'b0, coinc, mode};

  // Access decode
  always_comb begin
    lcdc_d    = lcdc_q;
    stat_hi_d = stat_hi_q;
    scy_d     = scy_q;
    scx_d     = scx_q;
    lyc_d     = lyc_q;
    bgp_d     = bgp_q;
    obp_d     = obp_q;
    wpos_d    = wpos_q;
    rsp_d     = '0;
    logged    = 1'b0;

    if (pos_i.acc.is_write == lcdr_pkg::AccWrite) begin
      unique case (pos_i.acc.offset)
        lcdr_pkg::OffLcdc: begin
          lcdc_d = pos_i.acc.wdata;
          logged = 1'b1;
        end
        lcdr_pkg::OffStat: stat_hi_d = pos_i.acc.wdata[7:4];
        lcdr_pkg::OffScy: begin
          scy_d  = pos_i.acc.wdata;
          logged = 1'b1;
        end
        lcdr_pkg::OffScx: begin
          scx_d  = pos_i.acc.wdata;
          logged = 1'b1;
        end
        lcdr_pkg::OffLyc: begin
          lyc_d                     = pos_i.acc.wdata;
          rsp_d.compare_event_valid = 1'b1;
          rsp_d.compare_event_time  = pos_i.start + lcdr_pkg::TsW'(pos_i.tgt);
        end
        lcdr_pkg::OffDma: ;
        lcdr_pkg::OffBgp: begin
          bgp_d  = pos_i.acc.wdata;
          logged = 1'b1;
        end
        lcdr_pkg::OffObp0: begin
          obp_d[0] = pos_i.acc.wdata;
          logged   = 1'b1;
        end
        lcdr_pkg::OffObp1: begin
          obp_d[1] = pos_i.acc.wdata;
          logged   = 1'b1;
        end
        lcdr_pkg::OffWy: begin
          wpos_d[0] = pos_i.acc.wdata;
          logged    = 1'b1;
        end
        lcdr_pkg::OffWx: begin
          wpos_d[1] = pos_i.acc.wdata;
          logged    = 1'b1;
        end
        default: rsp_d.unimplemented = 1'b1;
      endcase
      rsp_d.log_valid    = logged;
      rsp_d.log_scanline = logged ? ly_val : 8'd0;
    end else begin
      unique case (pos_i.acc.offset)
        lcdr_pkg::OffLcdc: rsp_d.read_data = lcdc_q;
        lcdr_pkg::OffStat: rsp_d.read_data = stat_val;
        lcdr_pkg::OffScy:  rsp_d.read_data = scy_q;
        lcdr_pkg::OffScx:  rsp_d.read_data = scx_q;
        lcdr_pkg::OffLy:   rsp_d.read_data = ly_val;
        lcdr_pkg::OffBgp:  rsp_d.read_data = bgp_q;
        lcdr_pkg::OffObp0: rsp_d.read_data = obp_q[0];
        lcdr_pkg::OffObp1: rsp_d.read_data = obp_q[1];
        default: begin
          rsp_d.read_data     = 8'hFF;
          rsp_d.unimplemented = 1'b1;
        end
      endcase
    end
  end

  // Register state, updated in request order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q    <= '0;
      stat_hi_q <= '0;
      scy_q     <= '0;
      scx_q     <= '0;
      lyc_q     <= '0;
      bgp_q     <= '0;
      obp_q     <= '0;
      wpos_q    <= '0;
    end else if (load_i) begin
      lcdc_q    <= lcdc_d;
      stat_hi_q <= stat_hi_d;
      scy_q     <= scy_d;
      scx_q     <= scx_d;
      lyc_q     <= lyc_d;
      bgp_q     <= bgp_d;
      obp_q     <= obp_d;
      wpos_q    <= wpos_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- rtl/lcd_register_file_with_timing_status_unit.sv -----
// Top level of the LCD register file with timing status.
//
//  Channel | Dir | Handshake     | Carries
//  req_i   | in  | valid/ready   | req_type, reg_offset, write_data, timestamp
//  rsp_o   | out | valid/ready   | read_data, unimplemented, log_valid, log_scanline,
//          |     |               | compare_event_valid, compare_event_time
//
// One request per cycle unless a stalled result has filled the pipeline. Each request
// passes the timestamp-to-frame-position pipeline (fold, quotient estimate,
// remainder, correction, line divide) ahead of the register stage.
// Empty pipeline stages close up under a stalled result, so requests keep
// flowing until all nine stages hold one. Reset clears the registers and the
// valid chain at once; no warm-up is needed.
module lcd_register_file_with_timing_status_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcdr_req_if.sink   req_i,
  lcdr_rsp_if.source rsp_o
);

  lcdr_pkg::pipe_ctl_t ctl;
  lcdr_pkg::acc_t      acc_in;
  lcdr_pkg::pos_t      pos;
  lcdr_pkg::rsp_t      rsp;

  assign acc_in.is_write = req_i.req_type;
  assign acc_in.offset   = req_i.reg_offset;
  assign acc_in.wdata    = req_i.write_data;

  lcdr_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  lcdr_frame_pos u_pos (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .acc_i (acc_in),
    .ts_i  (req_i.timestamp),
    .pos_o (pos)
  );

  lcdr_regfile u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctl.load[lcdr_pkg::NumStages-1]),
    .pos_i  (pos),
    .rsp_o  (rsp)
  );

  assign rsp_o.read_data           = rsp.read_data;
  assign rsp_o.unimplemented       = rsp.unimplemented;
  assign rsp_o.log_valid           = rsp.log_valid;
  assign rsp_o.log_scanline        = rsp.log_scanline;
  assign rsp_o.compare_event_valid = rsp.compare_event_valid;
  assign rsp_o.compare_event_time  = rsp.compare_event_time;

endmodule

// ----- rtl/lcdr_checker.sv -----
// Port-level checks on the result channel of the LCD register file.
module lcdr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lcdr_pkg::DataW-1:0] read_data_i,
  input logic                       unimpl_i,
  input logic                       log_valid_i,
  input logic [7:0]                 log_scanline_i,
  input logic                       ev_valid_i,
  input logic [lcdr_pkg::TsW-1:0]   ev_time_i
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_data_i)
      && $stable(unimpl_i) && $stable(log_valid_i) && $stable(log_scanline_i)
      && $stable(ev_valid_i) && $stable(ev_time_i))
    else $error("result changed while stalled");

  // A logged write reads zero and raises nothing else
  a_log_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && log_valid_i |-> read_data_i == '0 && !unimpl_i && !ev_valid_i)
    else $error("logged write with other flags");

  // A compare-line write is neither logged nor unimplemented
  a_ev_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ev_valid_i |-> read_data_i == '0 && !unimpl_i && !log_valid_i)
    else $error("compare event with other flags");

  // Unimplemented offsets give 0xFF on reads, zero on writes, no side reports
  a_unimpl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && unimpl_i |-> !log_valid_i && !ev_valid_i
      && (read_data_i == 8'hFF || read_data_i == 8'h00))
    else $error("bad unimplemented result");

  // Logged scanline lies within the frame
  a_scanline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && log_valid_i |-> log_scanline_i < 8'(lcdr_pkg::LinesPerFrame))
    else $error("logged scanline out of frame");

endmodule

bind lcd_register_file_with_timing_status_unit lcdr_checker u_lcdr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .read_data_i    (rsp_o.read_data),
  .unimpl_i       (rsp_o.unimplemented),
  .log_valid_i    (rsp_o.log_valid),
  .log_scanline_i (rsp_o.log_scanline),
  .ev_valid_i     (rsp_o.compare_event_valid),
  .ev_time_i      (rsp_o.compare_event_time)
);
